// File: rtl/hcb_pkg.sv
// Shared constants, types and the symbol alphabet of the Huffman code builder.
`default_nettype none
package hcb_pkg;

   localparam int NUM_SYMBOLS = 6;
   localparam int COUNT_BITS  = 16;
   localparam int NUM_NODES   = 2 * NUM_SYMBOLS - 1;
   localparam int NUM_INNER   = NUM_SYMBOLS - 1;
   localparam int ROOT_INDEX  = 2 * NUM_SYMBOLS - 2;
   localparam int WEIGHT_BITS = COUNT_BITS + $clog2(NUM_SYMBOLS);
   localparam int NODE_BITS   = $clog2(NUM_NODES);
   localparam int SYM_BITS    = $clog2(NUM_SYMBOLS);
   localparam int INNER_BITS  = (NUM_INNER > 1) ? $clog2(NUM_INNER) : 1;
   localparam int LIST_BITS   = $clog2(NUM_SYMBOLS + 1);
   localparam int CODE_BITS   = 5;
   localparam int LEN_BITS    = 3;
   localparam int MODE_BITS   = 3;
   localparam int KIND_BITS   = 2;

   localparam logic [MODE_BITS-1:0] MODE_COUNT  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_BUILD  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_ENCODE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_DECODE = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_CODE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CHAR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic build_init;
      logic sort_step;
      logic merge_step;
      logic emit_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic sort_last;
      logic merge_last;
   } status_type;

   // Character byte of each symbol.
   function automatic logic [7:0] sym_char(input logic [SYM_BITS-1:0] idx);
      logic [7:0] c;
      unique case (4'(idx))
         4'd0: c = "a";
         4'd1: c = "b";
         4'd2: c = "c";
         4'd3: c = "d";
         4'd4: c = "e";
         4'd5: c = "F";
         4'd6: c = "g";
         4'd7: c = "h";
         4'd8: c = "i";
         4'd9: c = "j";
         4'd10: c = "k";
         4'd11: c = "l";
         4'd12: c = "m";
         4'd13: c = "n";
         4'd14: c = "o";
         default: c = "p";
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/huffman_code_builder_codec.sv
// Top level of the Huffman code builder and codec for a six-symbol alphabet.
// Count, clear, encode and decode items may follow back to back while the output register is free;
// any result is registered and appears in the output register in the cycle after its item is accepted.
// A build sorts the NUM_SYMBOLS leaves, one leaf per cycle, then does NUM_SYMBOLS-1 merges,
// one merge per cycle, and posts its done result once the output register is free.
// Synchronous active-high reset clears the counts, the code-ready flag and the decode walk.
`default_nettype none
module huffman_code_builder_codec (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hcb_pkg::MODE_BITS-1:0] req_mode,
   input  wire logic [7:0]                    req_char_in,
   input  wire logic                          req_code_bit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [hcb_pkg::KIND_BITS-1:0]      rsp_result_kind,
   output logic [hcb_pkg::CODE_BITS-1:0]      rsp_codeword,
   output logic [hcb_pkg::LEN_BITS-1:0]       rsp_code_length,
   output logic [7:0]                         rsp_decoded_char
);

   // The controller owns sequencing; the datapath owns all data storage and the result register.
   hcb_pkg::cmd_type    cmd;
   hcb_pkg::status_type status;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hcb_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_char_in      (req_char_in),
      .req_code_bit     (req_code_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_codeword     (rsp_codeword),
      .rsp_code_length  (rsp_code_length),
      .rsp_decoded_char (rsp_decoded_char)
   );

   // A build item blocks the input for at least the following cycle.
   a_build_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == hcb_pkg::MODE_BUILD |=> !req_ready)
      else $error("input accepted during a build");

   // Only codeword items carry a code length.
   a_len_only_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != hcb_pkg::KIND_CODE |-> rsp_code_length == '0)
      else $error("code length on a non-codeword item");

   // Only decode items carry a character.
   a_char_only_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != hcb_pkg::KIND_CHAR |-> rsp_decoded_char == '0)
      else $error("decoded character on a non-decode item");

   // At most one datapath command fires at a time.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.build_init, cmd.sort_step, cmd.merge_step, cmd.emit_done}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// File: rtl/hcb_ctrl.sv
// Sequencing controller: accepts items and steps the tree build.
`default_nettype none
module hcb_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [hcb_pkg::MODE_BITS-1:0] req_mode,
   output logic                               req_ready,
   input  wire hcb_pkg::status_type           status,
   output hcb_pkg::cmd_type                   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SORT  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_mode == hcb_pkg::MODE_BUILD) begin
                  cmd.build_init = 1'b1;
                  state_in       = ST_SORT;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_SORT: begin
            cmd.sort_step = 1'b1;
            if (status.sort_last) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge_step = 1'b1;
            if (status.merge_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: rtl/hcb_dpath.sv
// Datapath: counts, sorted node list, merge step, code lanes, tree and result register.
`default_nettype none
module hcb_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hcb_pkg::cmd_type              cmd,
   output hcb_pkg::status_type                status,
   input  wire logic [hcb_pkg::MODE_BITS-1:0] req_mode,
   input  wire logic [7:0]                    req_char_in,
   input  wire logic                          req_code_bit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [hcb_pkg::KIND_BITS-1:0]      rsp_result_kind,
   output logic [hcb_pkg::CODE_BITS-1:0]      rsp_codeword,
   output logic [hcb_pkg::LEN_BITS-1:0]       rsp_code_length,
   output logic [7:0]                         rsp_decoded_char
);

   localparam int NS = hcb_pkg::NUM_SYMBOLS;

   logic [hcb_pkg::COUNT_BITS-1:0]  counts_ff [NS];
   logic [hcb_pkg::NODE_BITS-1:0]   list_id_ff [NS];
   logic [hcb_pkg::WEIGHT_BITS-1:0] list_w_ff [NS];
   logic [NS-1:0]                   list_m_ff [NS];
   logic [hcb_pkg::LIST_BITS-1:0]   list_n_ff;
   logic [hcb_pkg::SYM_BITS-1:0]    idx_ff;
   logic [hcb_pkg::NODE_BITS-1:0]   next_ff;
   logic [2*hcb_pkg::NODE_BITS-1:0] child_ff [hcb_pkg::NUM_INNER];
   logic [hcb_pkg::CODE_BITS-1:0]   code_ff [NS];
   logic [hcb_pkg::LEN_BITS-1:0]    len_ff [NS];
   logic [hcb_pkg::NODE_BITS-1:0]   dec_node_ff;
   logic                            code_ready_ff;

   logic                            rsp_valid_ff;
   logic [hcb_pkg::KIND_BITS-1:0]   kind_ff;
   logic [hcb_pkg::CODE_BITS-1:0]   cw_ff;
   logic [hcb_pkg::LEN_BITS-1:0]    cl_ff;
   logic [7:0]                      dc_ff;

   // Symbol lookup of the input character.
   logic                         sym_hit;
   logic [hcb_pkg::SYM_BITS-1:0] sym_idx;
   always_comb begin
      sym_hit = 1'b0;
      sym_idx = '0;
      for (int i = 0; i < NS; i++) begin
         if (req_char_in == hcb_pkg::sym_char(hcb_pkg::SYM_BITS'(i))) begin
            sym_hit = 1'b1;
            sym_idx = hcb_pkg::SYM_BITS'(i);
         end
      end
   end

   // Stable rank of the leaf being sorted.
   logic [hcb_pkg::COUNT_BITS-1:0] sort_w;
   logic [hcb_pkg::SYM_BITS-1:0]   rank;
   always_comb begin
      sort_w = counts_ff[idx_ff];
      rank   = '0;
      for (int j = 0; j < NS; j++) begin
         if (counts_ff[j] < sort_w ||
             (counts_ff[j] == sort_w && hcb_pkg::SYM_BITS'(j) < idx_ff))
            rank = rank + 1'b1;
      end
   end

   // One merge of the two lightest list entries.
   logic [hcb_pkg::WEIGHT_BITS-1:0] mw;
   logic [hcb_pkg::LIST_BITS-1:0]   pos;
   always_comb begin
      mw  = list_w_ff[0] + list_w_ff[1];
      pos = '0;
      for (int i = 2; i < NS; i++) begin
         if (hcb_pkg::LIST_BITS'(i) < list_n_ff && list_w_ff[i] < mw)
            pos = pos + 1'b1;
      end
   end

   // Decode walk.
   logic [hcb_pkg::INNER_BITS-1:0] dec_slot;
   logic [hcb_pkg::NODE_BITS-1:0]  dec_child;
   logic                           dec_leaf;
   always_comb begin
      dec_slot  = hcb_pkg::INNER_BITS'(dec_node_ff - hcb_pkg::NODE_BITS'(NS));
      dec_child = req_code_bit
                ? child_ff[dec_slot][2*hcb_pkg::NODE_BITS-1:hcb_pkg::NODE_BITS]
                : child_ff[dec_slot][hcb_pkg::NODE_BITS-1:0];
      dec_leaf  = dec_child < hcb_pkg::NODE_BITS'(NS);
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.sort_last  = idx_ff == hcb_pkg::SYM_BITS'(NS - 1);
   assign status.merge_last = list_n_ff == hcb_pkg::LIST_BITS'(2);

   // Counts, ready flag and decode walk state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) counts_ff[i] <= '0;
         code_ready_ff <= 1'b0;
         dec_node_ff   <= hcb_pkg::NODE_BITS'(hcb_pkg::ROOT_INDEX);
      end else begin
         if (cmd.exec && req_mode == hcb_pkg::MODE_COUNT && sym_hit &&
             counts_ff[sym_idx] != '1)
            counts_ff[sym_idx] <= counts_ff[sym_idx] + 1'b1;
         if (cmd.exec && req_mode == hcb_pkg::MODE_CLEAR)
            for (int i = 0; i < NS; i++) counts_ff[i] <= '0;
         if (cmd.emit_done) begin
            code_ready_ff <= 1'b1;
            dec_node_ff   <= hcb_pkg::NODE_BITS'(hcb_pkg::ROOT_INDEX);
         end
         if (cmd.exec && req_mode == hcb_pkg::MODE_DECODE && code_ready_ff)
            dec_node_ff <= dec_leaf ? hcb_pkg::NODE_BITS'(hcb_pkg::ROOT_INDEX)
                                    : dec_child;
      end
   end

   // Build datapath: sort, merge and code lanes.
   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         idx_ff    <= '0;
         list_n_ff <= hcb_pkg::LIST_BITS'(NS);
         next_ff   <= hcb_pkg::NODE_BITS'(NS);
         for (int s = 0; s < NS; s++) begin
            code_ff[s] <= '0;
            len_ff[s]  <= '0;
         end
      end
      if (cmd.sort_step) begin
         idx_ff           <= idx_ff + 1'b1;
         list_id_ff[rank] <= hcb_pkg::NODE_BITS'(idx_ff);
         list_w_ff[rank]  <= hcb_pkg::WEIGHT_BITS'(sort_w);
         list_m_ff[rank]  <= NS'(1) << idx_ff;
      end
      if (cmd.merge_step) begin
         child_ff[hcb_pkg::INNER_BITS'(next_ff - hcb_pkg::NODE_BITS'(NS))] <=
            {list_id_ff[1], list_id_ff[0]};
         next_ff   <= next_ff + 1'b1;
         list_n_ff <= list_n_ff - 1'b1;
         for (int t = 0; t < NS; t++) begin
            if (hcb_pkg::LIST_BITS'(t) < pos) begin
               if (t + 2 < NS) begin
                  list_id_ff[t] <= list_id_ff[t+2];
                  list_w_ff[t]  <= list_w_ff[t+2];
                  list_m_ff[t]  <= list_m_ff[t+2];
               end
            end else if (hcb_pkg::LIST_BITS'(t) == pos) begin
               list_id_ff[t] <= next_ff;
               list_w_ff[t]  <= mw;
               list_m_ff[t]  <= list_m_ff[0] | list_m_ff[1];
            end else if (t + 1 < NS) begin
               list_id_ff[t] <= list_id_ff[t+1];
               list_w_ff[t]  <= list_w_ff[t+1];
               list_m_ff[t]  <= list_m_ff[t+1];
            end
         end
         for (int s = 0; s < NS; s++) begin
            if (list_m_ff[0][s]) begin
               len_ff[s] <= len_ff[s] + 1'b1;
            end else if (list_m_ff[1][s]) begin
               code_ff[s] <= code_ff[s] | (hcb_pkg::CODE_BITS'(1) << len_ff[s]);
               len_ff[s]  <= len_ff[s] + 1'b1;
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (cmd.emit_done) begin
            rsp_valid_ff <= 1'b1;
            kind_ff      <= hcb_pkg::KIND_DONE;
            cw_ff        <= '0;
            cl_ff        <= '0;
            dc_ff        <= '0;
         end else if (cmd.exec && req_mode == hcb_pkg::MODE_ENCODE &&
                      code_ready_ff && sym_hit) begin
            rsp_valid_ff <= 1'b1;
            kind_ff      <= hcb_pkg::KIND_CODE;
            cw_ff        <= code_ff[sym_idx];
            cl_ff        <= len_ff[sym_idx];
            dc_ff        <= '0;
         end else if (cmd.exec && req_mode == hcb_pkg::MODE_DECODE &&
                      code_ready_ff && dec_leaf) begin
            rsp_valid_ff <= 1'b1;
            kind_ff      <= hcb_pkg::KIND_CHAR;
            cw_ff        <= '0;
            cl_ff        <= '0;
            dc_ff        <= hcb_pkg::sym_char(hcb_pkg::SYM_BITS'(dec_child));
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_codeword     = cw_ff;
   assign rsp_code_length  = cl_ff;
   assign rsp_decoded_char = dc_ff;

endmodule
`default_nettype wire
